// ----- design/rrq_pkg.sv -----
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types and constants of the round-robin run queue scheduler.
// ----------------------------------------------------------------------------
package rrq_pkg;

  localparam int unsigned CMD_W       = 3;
  localparam int unsigned TID_W       = 4;
  localparam int unsigned NOW_W       = 48;
  localparam int unsigned QLEN_W      = 5;
  localparam int unsigned IDLE_W      = 4;
  localparam int unsigned THREADS_DEF = 16;
  localparam int unsigned TBITS_DEF   = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 3'd0,
    CMD_YIELD   = 3'd1,
    CMD_RESCHED = 3'd2,
    CMD_ADD     = 3'd3,
    CMD_REMOVE  = 3'd4,
    CMD_BLOCKED = 3'd5
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic rd;
    logic add;
  } acct_req_t;

endpackage

// ----- design/rrq_cmd_if.sv -----
// ----------------------------------------------------------------------------
// rrq_cmd_if
// Command channel: valid/ready with one scheduler command per transfer.
// ----------------------------------------------------------------------------
interface rrq_cmd_if;
  import rrq_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [TID_W-1:0]  thread_id;
  logic              thread_runnable;
  logic [NOW_W-1:0]  now;

  modport source (output valid, command, thread_id, thread_runnable, now, input ready);
  modport sink   (input valid, command, thread_id, thread_runnable, now, output ready);
endinterface

// ----- design/rrq_res_if.sv -----
// ----------------------------------------------------------------------------
// rrq_res_if
// Result channel: valid/ready with one scheduler result per transfer.
// ----------------------------------------------------------------------------
interface rrq_res_if;
  import rrq_pkg::*;

  logic              valid;
  logic              ready;
  logic [TID_W-1:0]  current_thread;
  logic              switched;
  logic [NOW_W-1:0]  time_charged;
  logic [QLEN_W-1:0] queue_length;
  logic              ignored;

  modport source (output valid, current_thread, switched, time_charged, queue_length,
                  ignored, input ready);
  modport sink   (input valid, current_thread, switched, time_charged, queue_length,
                  ignored, output ready);
endinterface

// ----- design/rrq_ram.sv -----
// ----------------------------------------------------------------------------
// rrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrq_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rrq_acct.sv -----
// ----------------------------------------------------------------------------
// rrq_acct
// Per-thread run time accounting: read, add the charge, write back.
// ----------------------------------------------------------------------------
module rrq_acct #(
  parameter int unsigned THREADS   = 16,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rrq_pkg::acct_req_t         req_i,
  input  logic [$clog2(THREADS)-1:0] addr_i,
  input  logic [TIME_BITS-1:0]       charge_i
);
  import rrq_pkg::*;

  localparam int unsigned TW = $clog2(THREADS);

  logic [TW-1:0]        addr_q;
  logic [THREADS-1:0]   vld_q;
  logic [TIME_BITS-1:0] rdata;
  logic [TIME_BITS-1:0] base;
  logic [TIME_BITS-1:0] sum;

  rrq_ram #(.WIDTH(TIME_BITS), .DEPTH(THREADS)) u_rt_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.add),
    .waddr_i (addr_q),
    .wdata_i (sum),
    .re_i    (req_i.rd),
    .raddr_i (addr_i),
    .rdata_o (rdata)
  );

  assign base = vld_q[addr_q] ? rdata : '0;
  assign sum  = base + charge_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      addr_q <= '0;
    end else begin
      if (req_i.rd) begin
        addr_q <= addr_i;
      end
      if (req_i.add) begin
        vld_q[addr_q] <= 1'b1;
      end
    end
  end

endmodule

// ----- design/round_robin_run_queue.sv -----
// ----------------------------------------------------------------------------
// round_robin_run_queue
// Round-robin run queue scheduler over a doubly linked thread table.
// ----------------------------------------------------------------------------
// At the transfer of a command the link table and the run time memory are read
// (registered read); in the next cycle the queue is updated and the links and
// run time are written back. The result sits in an output register; the next
// command is taken once that register is free or is being drained, and not
// while the previous command is still being updated.
// Run time entries carry valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module round_robin_run_queue #(
  parameter int unsigned THREADS   = rrq_pkg::THREADS_DEF,
  parameter int unsigned TIME_BITS = rrq_pkg::TBITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      idle_we_i,
  input  logic [rrq_pkg::IDLE_W-1:0] idle_wdata_i,
  rrq_cmd_if.sink                   cmd_i,
  rrq_res_if.source                 res_o
);
  import rrq_pkg::*;

  localparam int unsigned TW = $clog2(THREADS);
  localparam int unsigned CW = $clog2(THREADS + 1);

  function automatic logic [TW-1:0] idle_mod(input logic [IDLE_W-1:0] v);
    logic [8:0] r;
    r = 9'(v);
    for (int i = 0; i < 8; i++) begin
      if (r >= 9'(THREADS)) begin
        r = r - 9'(THREADS);
      end
    end
    return TW'(r);
  endfunction

  state_e state_q, state_d;

  logic [TW-1:0]        idle_q;
  logic [TW-1:0]        head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [THREADS-1:0]   mark_q, mark_d;
  logic [TW-1:0]        running_q, running_d;
  logic [TIME_BITS-1:0] last_q, last_d;

  logic [CMD_W-1:0]     cmd_q;
  logic [TID_W-1:0]     tid_q;
  logic                 rnb_q;
  logic [TIME_BITS-1:0] now_q;

  logic                 out_vld_q;
  logic [TID_W-1:0]     out_cur_q;
  logic                 out_sw_q;
  logic [NOW_W-1:0]     out_time_q;
  logic [QLEN_W-1:0]    out_qlen_q;
  logic                 out_ign_q;

  logic          accept, sched_in;
  logic [TW-1:0] rd_addr, nxt_rd, prv_rd;
  logic          nxt_we, prv_we;
  logic [TW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;

  logic                 deq_en, enq_en, from_q, sw, ign, tid_ok;
  logic [TW-1:0]        deq_t, enq_t, pick, t;
  logic [TIME_BITS-1:0] charged;
  logic                 acct_add;
  acct_req_t            acct_req;

  assign cmd_i.ready = (state_q == ST_IDLE) && (!out_vld_q || res_o.ready);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign sched_in    = (cmd_i.command == CMD_YIELD) || (cmd_i.command == CMD_RESCHED);
  assign rd_addr     = sched_in ? head_q : TW'(cmd_i.thread_id);

  rrq_ram #(.WIDTH(TW), .DEPTH(THREADS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_wa),
    .wdata_i (nxt_wd),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (nxt_rd)
  );

  rrq_ram #(.WIDTH(TW), .DEPTH(THREADS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_wa),
    .wdata_i (prv_wd),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (prv_rd)
  );

  assign acct_req.rd  = accept;
  assign acct_req.add = acct_add;

  rrq_acct #(.THREADS(THREADS), .TIME_BITS(TIME_BITS)) u_acct (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (acct_req),
    .addr_i   (running_q),
    .charge_i (charged)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cnt_d        = cnt_q;
    mark_d       = mark_q;
    running_d    = running_q;
    last_d       = last_q;
    nxt_we       = 1'b0;
    nxt_wa       = '0;
    nxt_wd       = '0;
    prv_we       = 1'b0;
    prv_wa       = '0;
    prv_wd       = '0;
    deq_en       = 1'b0;
    deq_t        = '0;
    enq_en       = 1'b0;
    enq_t        = '0;
    from_q       = 1'b0;
    pick         = '0;
    sw           = 1'b0;
    ign          = 1'b0;
    charged      = '0;
    acct_add     = 1'b0;
    tid_ok       = (32'(tid_q) < THREADS);
    t            = TW'(tid_q);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        unique case (cmd_q)
          CMD_START: begin
            last_d = now_q;
          end
          CMD_YIELD, CMD_RESCHED: begin
            if (cmd_q == CMD_YIELD || !rnb_q) begin
              charged  = now_q - last_q;
              acct_add = 1'b1;
              last_d   = now_q;
              if (cnt_q != '0) begin
                pick   = head_q;
                from_q = 1'b1;
              end else if (rnb_q) begin
                pick = running_q;
              end else begin
                pick = idle_q;
              end
              if (pick != running_q) begin
                sw        = 1'b1;
                running_d = pick;
                deq_en    = from_q;
                deq_t     = head_q;
                enq_en    = (running_q != idle_q) && rnb_q && !mark_q[running_q];
                enq_t     = running_q;
              end
            end
          end
          CMD_ADD: begin
            if (!tid_ok || t == idle_q) begin
              ign = 1'b1;
            end else if (rnb_q && t != running_q) begin
              if (mark_q[t]) begin
                ign = 1'b1;
              end else begin
                enq_en = 1'b1;
                enq_t  = t;
              end
            end
          end
          CMD_REMOVE, CMD_BLOCKED: begin
            if (!tid_ok || t == idle_q) begin
              ign = 1'b1;
            end else if (t != running_q && (cmd_q == CMD_BLOCKED || rnb_q)) begin
              if (mark_q[t]) begin
                deq_en = 1'b1;
                deq_t  = t;
              end else begin
                ign = 1'b1;
              end
            end
          end
          default: begin
            ign = 1'b1;
          end
        endcase

        if (deq_en) begin
          if (deq_t == head_q) begin
            head_d = nxt_rd;
          end else begin
            nxt_we = 1'b1;
            nxt_wa = prv_rd;
            nxt_wd = nxt_rd;
          end
          if (deq_t == tail_q) begin
            tail_d = prv_rd;
          end else if (deq_t != head_q) begin
            prv_we = 1'b1;
            prv_wa = nxt_rd;
            prv_wd = prv_rd;
          end
          mark_d[deq_t] = 1'b0;
          cnt_d         = cnt_d - CW'(1);
          if (cnt_d == '0) begin
            head_d = '0;
            tail_d = '0;
          end
        end

        if (enq_en) begin
          if (cnt_d == '0) begin
            head_d = enq_t;
          end else begin
            nxt_we = 1'b1;
            nxt_wa = tail_d;
            nxt_wd = enq_t;
            prv_we = 1'b1;
            prv_wa = enq_t;
            prv_wd = tail_d;
          end
          tail_d        = enq_t;
          mark_d[enq_t] = 1'b1;
          cnt_d         = cnt_d + CW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q    <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      mark_q    <= '0;
      running_q <= '0;
      last_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (idle_we_i) begin
        idle_q <= idle_mod(idle_wdata_i);
      end
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      mark_q    <= mark_d;
      running_q <= running_d;
      last_q    <= last_d;
      if (state_q == ST_EXEC) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i.command;
      tid_q <= cmd_i.thread_id;
      rnb_q <= cmd_i.thread_runnable;
      now_q <= TIME_BITS'(cmd_i.now);
    end
    if (state_q == ST_EXEC) begin
      out_cur_q  <= TID_W'(running_d);
      out_sw_q   <= sw;
      out_time_q <= NOW_W'(charged);
      out_qlen_q <= QLEN_W'(cnt_d);
      out_ign_q  <= ign;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.current_thread = out_cur_q;
  assign res_o.switched       = out_sw_q;
  assign res_o.time_charged   = out_time_q;
  assign res_o.queue_length   = out_qlen_q;
  assign res_o.ignored        = out_ign_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= THREADS) else $error("run queue count exceeds thread count");

  a_mark_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(mark_q) == 32'(cnt_q)) else $error("queued marks disagree with count");

  a_exec_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC) else $error("transfer not followed by update");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |=> out_vld_q) else $error("update produced no result");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> head_q == '0 && tail_q == '0) else $error("empty queue pointers");
`endif

endmodule
